// File: design/ps2kb_pkg.sv
// ----------------------------------------------------------------------------
// ps2kb_pkg
// Shared types and constants of the PS/2 keyboard receiver and decoder.
// ----------------------------------------------------------------------------
package ps2kb_pkg;

    localparam int FRAME_BITS  = 11;
    localparam int CNT_W       = $clog2(FRAME_BITS);
    localparam int SHIFT_W     = FRAME_BITS - 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 3;

    localparam logic [7:0] CODE_BREAK    = 8'hF0;
    localparam logic [7:0] CODE_EXTENDED = 8'hE0;
    localparam logic [7:0] KEY_ZERO_RST  = 8'h70;
    localparam logic [7:0] KEY_ONE_RST   = 8'h69;

    localparam logic [1:0] ST_PROGRESS = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic REG_KEY_ZERO = 1'b0;
    localparam logic REG_KEY_ONE  = 1'b1;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data;
    } frame_entry_t;

    typedef struct packed {
        logic [7:0] key_zero;
        logic [7:0] key_one;
    } key_cfg_t;

endpackage

// File: design/ps2kb_frame_rx.sv
// ----------------------------------------------------------------------------
// ps2kb_frame_rx
// Assembles keyboard clock edges into frames and classifies each edge.
// ----------------------------------------------------------------------------
module ps2kb_frame_rx import ps2kb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         edge_valid,
    input  logic         data_bit,
    output frame_entry_t entry
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);

    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;

    always_comb begin
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        entry.status = ST_PROGRESS;
        entry.data   = '0;
        if (bit_cnt_reg == '0 && data_bit) begin
            entry.status = ST_REJECTED;
        end else if (bit_cnt_reg == CNT_LAST) begin
            bit_cnt_next = '0;
            shift_next   = '0;
            if (!shift_reg[0] && data_bit) begin
                entry.status = ST_ACCEPTED;
                entry.data   = shift_reg[8:1];
            end else begin
                entry.status = ST_DROPPED;
            end
        end else begin
            bit_cnt_next = bit_cnt_reg + 1'b1;
            shift_next   = {data_bit, shift_reg[SHIFT_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
        end else if (edge_valid) begin
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
        end
    end

endmodule

// File: design/ps2kb_queue.sv
// ----------------------------------------------------------------------------
// ps2kb_queue
// Short queue of classified edges between the frame receiver and decoder.
// ----------------------------------------------------------------------------
module ps2kb_queue import ps2kb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  frame_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output frame_entry_t pop_entry
);

    frame_entry_t      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/ps2kb_decode.sv
// ----------------------------------------------------------------------------
// ps2kb_decode
// Decodes accepted bytes into prefix flags and indicator states and holds
// the result transaction in an output register.
// ----------------------------------------------------------------------------
module ps2kb_decode import ps2kb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  key_cfg_t     key_cfg,
    input  logic         entry_valid,
    input  frame_entry_t entry,
    output logic         entry_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_frame_status,
    output logic [7:0]   m_received_byte,
    output logic         m_indicator_zero,
    output logic         m_indicator_one,
    output logic         m_break_flag_out,
    output logic         m_extended_flag_out
);

    logic       brk_reg, brk_next;
    logic       ext_reg, ext_next;
    logic       led0_reg, led0_next;
    logic       led1_reg, led1_next;
    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic [7:0] byte_reg;

    assign entry_pop = entry_valid && (!out_valid_reg || m_ready);

    always_comb begin
        brk_next  = brk_reg;
        ext_next  = ext_reg;
        led0_next = led0_reg;
        led1_next = led1_reg;
        if (entry.status == ST_ACCEPTED) begin
            priority if (entry.data == CODE_EXTENDED) begin
                ext_next = 1'b1;
            end else if (entry.data == CODE_BREAK) begin
                brk_next = 1'b1;
            end else if (entry.data == key_cfg.key_zero) begin
                led0_next = !brk_reg;
                brk_next  = 1'b0;
                ext_next  = 1'b0;
            end else if (entry.data == key_cfg.key_one) begin
                led1_next = !brk_reg;
                brk_next  = 1'b0;
                ext_next  = 1'b0;
            end else begin
                brk_next = brk_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brk_reg       <= 1'b0;
            ext_reg       <= 1'b0;
            led0_reg      <= 1'b0;
            led1_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (entry_pop) begin
                brk_reg  <= brk_next;
                ext_reg  <= ext_next;
                led0_reg <= led0_next;
                led1_reg <= led1_next;
            end
            if (entry_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (entry_pop) begin
            status_reg <= entry.status;
            byte_reg   <= entry.data;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_frame_status      = status_reg;
    assign m_received_byte     = byte_reg;
    assign m_indicator_zero    = led0_reg;
    assign m_indicator_one     = led1_reg;
    assign m_break_flag_out    = brk_reg;
    assign m_extended_flag_out = ext_reg;

endmodule

// File: design/ps2_keyboard_receive_decode.sv
// m_valid rises once an accepted edge transaction has passed the queue write and then the
// decode register; a result-side stall can hold it in the queue before the decode register.
// Throughput: one edge per cycle, sustained while the result side takes one per cycle.
// The two-entry queue between frame receiver and decoder absorbs result-side stalls.
// Reset: aresetn low clears the frame counter, flags, indicators and queue and
// restores the key code registers to 0x70 and 0x69; no clearing pass follows.
// ----------------------------------------------------------------------------
// ps2_keyboard_receive_decode
// PS/2 keyboard frame receiver with scan code set 2 key decoding.
// ----------------------------------------------------------------------------
module ps2_keyboard_receive_decode import ps2kb_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_data_bit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_frame_status,
    output logic [7:0]         m_received_byte,
    output logic               m_indicator_zero,
    output logic               m_indicator_one,
    output logic               m_break_flag_out,
    output logic               m_extended_flag_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    key_cfg_t     key_cfg_reg;
    frame_entry_t rx_entry;
    frame_entry_t q_entry;
    logic         q_full;
    logic         q_not_empty;
    logic         q_pop;
    logic         in_push;
    logic         cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == REG_KEY_ONE) ? {24'd0, key_cfg_reg.key_one}
                                               : {24'd0, key_cfg_reg.key_zero};
    assign s_ready = !q_full;
    assign in_push = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_cfg_reg.key_zero <= KEY_ZERO_RST;
            key_cfg_reg.key_one  <= KEY_ONE_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_KEY_ZERO) begin
                key_cfg_reg.key_zero <= pwdata[7:0];
            end else begin
                key_cfg_reg.key_one <= pwdata[7:0];
            end
        end
    end

    ps2kb_frame_rx u_frame_rx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .edge_valid (in_push),
        .data_bit   (s_data_bit),
        .entry      (rx_entry)
    );

    ps2kb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (in_push),
        .push_entry (rx_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .pop_entry  (q_entry)
    );

    ps2kb_decode u_decode (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .key_cfg             (key_cfg_reg),
        .entry_valid         (q_not_empty),
        .entry               (q_entry),
        .entry_pop           (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_frame_status      (m_frame_status),
        .m_received_byte     (m_received_byte),
        .m_indicator_zero    (m_indicator_zero),
        .m_indicator_one     (m_indicator_one),
        .m_break_flag_out    (m_break_flag_out),
        .m_extended_flag_out (m_extended_flag_out)
    );

`ifndef SYNTH
    a_byte_only_when_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_status != ST_ACCEPTED) |-> (m_received_byte == 8'd0))
        else $error("received byte nonzero outside an accepted frame");

    a_break_prefix_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_status == ST_ACCEPTED) && (m_received_byte == CODE_BREAK)
        |-> m_break_flag_out)
        else $error("break prefix did not set the break flag");

    a_ext_prefix_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_status == ST_ACCEPTED) && (m_received_byte == CODE_EXTENDED)
        |-> m_extended_flag_out)
        else $error("extended prefix did not set the extended flag");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !in_push)
        else $error("edge accepted while the queue is full");
`endif

endmodule
